// ===== src/nted_pkg.sv =====
// Package for the note event debouncer: payload structs, mode encoding,
// configuration register indexes and reset values. No dependencies.
`default_nettype none

package nted_pkg;

  typedef struct packed {
    logic [6:0]  note_number;
    logic [6:0]  velocity;
    logic [6:0]  expression;
    logic [13:0] pitch_bend;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic [6:0]  out_expression;
    logic [13:0] out_bend;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_HOLD_NOTE     = 2'd0,
    MODE_HOLD_MUTE     = 2'd1,
    MODE_CHANGING_NOTE = 2'd2,
    MODE_CHANGING_MUTE = 2'd3
  } mode_e;

  typedef struct packed {
    logic [7:0]  hold_count;
    logic [7:0]  large_jump_count;
    logic [6:0]  max_semitone_step;
    logic [13:0] bend_change_step;
    logic [6:0]  expression_change_step;
  } cfg_t;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 14;

  localparam logic [CfgIdxW-1:0] CFG_HOLD_COUNT        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LARGE_JUMP_COUNT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SEMITONE_STEP = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BEND_CHANGE_STEP  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_EXPR_CHANGE_STEP  = 3'd4;

  localparam logic [7:0]  HOLD_COUNT_RST        = 8'd3;
  localparam logic [7:0]  LARGE_JUMP_COUNT_RST  = 8'd6;
  localparam logic [6:0]  MAX_SEMITONE_STEP_RST = 7'd2;
  localparam logic [13:0] BEND_CHANGE_STEP_RST  = 14'd1600;
  localparam logic [6:0]  EXPR_CHANGE_STEP_RST  = 7'd5;

  localparam logic [7:0]  RUN_COUNT_MAX = 8'd255;

endpackage

`default_nettype wire

// ===== src/note_event_debouncer.sv =====
// Top level of the note event debouncer: input register, debounce core,
// result register and configuration registers. Uses nted_pkg, nted_cfg, nted_core.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-----------------------
//   in       | into      | in_valid_i / in_stall_o   | in_item_i  (in_item_t)
//   out      | out of    | out_valid_o / out_stall_i | out_item_o (out_item_t)
//   cfg      | into      | cfg_we_i, cfg_idx_i       | cfg_wdata_i (14 bit)
//
// An event is taken into the input register; once the result register is free,
// the core decides on it and loads the result register when a note or mute is
// emitted. Throughput is one event per cycle while out_stall_i does not hold the
// result register, set by the single pass through the core's state update.
// Reset puts the machine in changing-note mode with run count one and loads
// the configuration reset values. The input is stalled only while an event
// waits in the input register and the result register is held by out_stall_i.
`default_nettype none

module note_event_debouncer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire nted_pkg::in_item_t              in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output nted_pkg::out_item_t                  out_item_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [nted_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [nted_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  nted_pkg::cfg_t      cfg;
  nted_pkg::in_item_t  in_item_q;
  nted_pkg::out_item_t out_item_q, result;
  logic                in_vld_d, in_vld_q, out_vld_d, out_vld_q;
  logic                in_accept, out_free, advance, emit;

  // The result register can take a new transaction when empty or being drained.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  nted_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  nted_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .emit_o   (emit),
    .result_o (result)
  );

  // Input register: load on accept, drop once the core has consumed it.
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // Result register: hold while stalled, otherwise take the core's decision.
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = advance && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
    if (advance && emit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== src/nted_cfg.sv =====
// Configuration register file of the note event debouncer.
// Depends on nted_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module nted_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [nted_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [nted_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output nted_pkg::cfg_t                       cfg_o
);

  nted_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nted_pkg::CFG_HOLD_COUNT:        cfg_d.hold_count = cfg_wdata_i[7:0];
        nted_pkg::CFG_LARGE_JUMP_COUNT:  cfg_d.large_jump_count = cfg_wdata_i[7:0];
        nted_pkg::CFG_MAX_SEMITONE_STEP: cfg_d.max_semitone_step = cfg_wdata_i[6:0];
        nted_pkg::CFG_BEND_CHANGE_STEP:  cfg_d.bend_change_step = cfg_wdata_i[13:0];
        nted_pkg::CFG_EXPR_CHANGE_STEP:  cfg_d.expression_change_step = cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_count             <= nted_pkg::HOLD_COUNT_RST;
      cfg_q.large_jump_count       <= nted_pkg::LARGE_JUMP_COUNT_RST;
      cfg_q.max_semitone_step      <= nted_pkg::MAX_SEMITONE_STEP_RST;
      cfg_q.bend_change_step       <= nted_pkg::BEND_CHANGE_STEP_RST;
      cfg_q.expression_change_step <= nted_pkg::EXPR_CHANGE_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/nted_core.sv =====
// Debounce state machine: mode, run counter, peaks, candidate and held event.
// Depends on nted_pkg for in_item_t, out_item_t, cfg_t and mode_e.
`default_nettype none

module nted_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire nted_pkg::in_item_t  item_i,
  input  wire nted_pkg::cfg_t      cfg_i,
  output logic                     emit_o,
  output nted_pkg::out_item_t      result_o
);

  nted_pkg::mode_e mode_d, mode_q;
  logic [7:0]  run_d, run_q, run_inc;
  logic [6:0]  peak_vel_d, peak_vel_q, peak_expr_d, peak_expr_q;
  logic [6:0]  cand_note_d, cand_note_q, cand_vel_d, cand_vel_q;
  logic [6:0]  cand_expr_d, cand_expr_q;
  logic [13:0] cand_bend_d, cand_bend_q;
  logic [6:0]  held_note_d, held_note_q, held_vel_d, held_vel_q;
  logic [6:0]  held_expr_d, held_expr_q;
  logic [13:0] held_bend_d, held_bend_q;
  logic [6:0]  note_diff, expr_diff;
  logic [13:0] bend_diff;
  logic        small_jump, count_met, bend_moved, expr_moved;
  logic [6:0]  n, v, e;
  logic [13:0] b;

  assign n = item_i.note_number;
  assign v = item_i.velocity;
  assign e = item_i.expression;
  assign b = item_i.pitch_bend;

  assign run_inc    = (run_q == nted_pkg::RUN_COUNT_MAX) ? run_q : run_q + 8'd1;
  assign note_diff  = (held_note_q > n) ? held_note_q - n : n - held_note_q;
  assign expr_diff  = (held_expr_q > e) ? held_expr_q - e : e - held_expr_q;
  assign bend_diff  = (held_bend_q > b) ? held_bend_q - b : b - held_bend_q;
  assign small_jump = note_diff <= cfg_i.max_semitone_step;
  assign bend_moved = bend_diff >= cfg_i.bend_change_step;
  assign expr_moved = expr_diff >= cfg_i.expression_change_step;

  always_comb begin
    mode_d      = mode_q;
    run_d       = run_q;
    peak_vel_d  = peak_vel_q;
    peak_expr_d = peak_expr_q;
    cand_note_d = cand_note_q;
    cand_vel_d  = cand_vel_q;
    cand_expr_d = cand_expr_q;
    cand_bend_d = cand_bend_q;
    held_note_d = held_note_q;
    held_vel_d  = held_vel_q;
    held_expr_d = held_expr_q;
    held_bend_d = held_bend_q;
    count_met   = 1'b0;
    emit_o      = 1'b0;

    unique case (mode_q)
      nted_pkg::MODE_CHANGING_NOTE: begin
        if (v == 7'd0) begin
          mode_d = (held_vel_q == 7'd0) ? nted_pkg::MODE_HOLD_MUTE
                                        : nted_pkg::MODE_CHANGING_MUTE;
          run_d  = 8'd1;
        end else if (n != cand_note_q && n == held_note_q) begin
          // back to the held note: drop the run
          mode_d      = nted_pkg::MODE_HOLD_NOTE;
          run_d       = 8'd1;
          peak_vel_d  = 7'd0;
          peak_expr_d = 7'd0;
        end else begin
          if (n == cand_note_q) begin
            run_d = run_inc;
            if (v > peak_vel_q) begin
              peak_vel_d  = v;
              peak_expr_d = e;
            end
          end else begin
            cand_note_d = n;
            cand_vel_d  = v;
            cand_expr_d = e;
            cand_bend_d = b;
            run_d       = 8'd1;
            peak_vel_d  = v;
            peak_expr_d = e;
          end
          count_met = ((run_d >= cfg_i.hold_count) &&
                       (small_jump || held_note_q == 7'd0)) ||
                      ((run_d >= cfg_i.large_jump_count) && !small_jump);
          if (count_met) begin
            held_note_d = cand_note_d;
            held_bend_d = cand_bend_d;
            held_vel_d  = peak_vel_d;
            held_expr_d = peak_expr_d;
            mode_d      = nted_pkg::MODE_HOLD_NOTE;
            emit_o      = 1'b1;
          end
        end
      end
      nted_pkg::MODE_CHANGING_MUTE: begin
        if (v != 7'd0 && n == held_note_q) begin
          mode_d      = nted_pkg::MODE_HOLD_NOTE;
          run_d       = 8'd1;
          peak_vel_d  = 7'd0;
          peak_expr_d = 7'd0;
        end else begin
          if (v == 7'd0) begin
            run_d = run_inc;
          end else begin
            cand_note_d = n;
            cand_vel_d  = v;
            cand_expr_d = e;
            cand_bend_d = b;
            run_d       = 8'd1;
            peak_vel_d  = v;
            peak_expr_d = e;
            mode_d      = nted_pkg::MODE_CHANGING_NOTE;
          end
          if (run_d >= cfg_i.hold_count) begin
            held_note_d = n;
            held_vel_d  = v;
            held_expr_d = e;
            held_bend_d = b;
            mode_d      = nted_pkg::MODE_HOLD_MUTE;
            emit_o      = 1'b1;
          end
        end
      end
      nted_pkg::MODE_HOLD_NOTE: begin
        if (n != held_note_q) begin
          cand_note_d = n;
          cand_vel_d  = v;
          cand_expr_d = e;
          cand_bend_d = b;
          run_d       = 8'd1;
          peak_vel_d  = v;
          peak_expr_d = e;
          mode_d      = nted_pkg::MODE_CHANGING_NOTE;
        end else if (bend_moved || expr_moved) begin
          held_bend_d = b;
          held_vel_d  = v;
          held_expr_d = e;
          emit_o      = 1'b1;
        end
      end
      nted_pkg::MODE_HOLD_MUTE: begin
        if (v != 7'd0) begin
          cand_note_d = n;
          cand_vel_d  = v;
          cand_expr_d = e;
          cand_bend_d = b;
          run_d       = 8'd1;
          peak_vel_d  = v;
          peak_expr_d = e;
          mode_d      = nted_pkg::MODE_CHANGING_NOTE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= nted_pkg::MODE_CHANGING_NOTE;
      run_q       <= 8'd1;
      peak_vel_q  <= 7'd0;
      peak_expr_q <= 7'd0;
      cand_note_q <= 7'd0;
      cand_vel_q  <= 7'd0;
      cand_expr_q <= 7'd0;
      cand_bend_q <= 14'd0;
      held_note_q <= 7'd0;
      held_vel_q  <= 7'd0;
      held_expr_q <= 7'd0;
      held_bend_q <= 14'd0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      run_q       <= run_d;
      peak_vel_q  <= peak_vel_d;
      peak_expr_q <= peak_expr_d;
      cand_note_q <= cand_note_d;
      cand_vel_q  <= cand_vel_d;
      cand_expr_q <= cand_expr_d;
      cand_bend_q <= cand_bend_d;
      held_note_q <= held_note_d;
      held_vel_q  <= held_vel_d;
      held_expr_q <= held_expr_d;
      held_bend_q <= held_bend_d;
    end
  end

  assign result_o.out_note       = held_note_d;
  assign result_o.out_velocity   = held_vel_d;
  assign result_o.out_expression = held_expr_d;
  assign result_o.out_bend       = held_bend_d;

endmodule

`default_nettype wire

// ===== src/nted_checker.sv =====
// Port-level checker for the note event debouncer, bound to the top level.
// Depends on nted_pkg and note_event_debouncer.
`default_nettype none

module nted_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_o,
  input  wire logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  input  wire nted_pkg::out_item_t             out_item_o
);

  // A stalled result transaction holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or vanished");

  // No result while in reset.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // With the result register empty the input is never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // A fresh result is preceded by an accepted input transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching input transaction");

endmodule

bind note_event_debouncer nted_checker u_nted_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== bench/tb_note_event_debouncer.sv =====
// Self-checking testbench for note_event_debouncer: directed table, then random
// note, mute and noise runs under several register settings. Uses nted_pkg and note_event_debouncer.
`default_nettype none

module tb_note_event_debouncer;

  localparam int HalfPeriod     = 6;
  localparam int HoldOffCycles  = 300;   // long receiver hold-off under pressure
  localparam int SettleCycles   = 4;     // margin for the input and result registers to run empty
  localparam int WatchdogLimit  = 3000;  // cycles without any transaction

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {
    ROW_PREDICTED,  // expectation comes from the predictor
    ROW_QUIET,      // no result allowed
    ROW_EMITS       // result typed into the table
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    nted_pkg::in_item_t  ev;
    nted_pkg::out_item_t typed;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block-side signals
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  always #HalfPeriod clk = ~clk;

  logic                          rst_n;
  logic                          in_valid;
  nted_pkg::in_item_t            in_item;
  logic                          in_stall;
  logic                          out_valid;
  logic                          out_stall;
  nted_pkg::out_item_t           out_item;
  logic                          cfg_we;
  logic [nted_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [nted_pkg::CfgDataW-1:0] cfg_wdata;

  // Travels alongside in_item so the input monitor knows how to check the row.
  row_kind_e                     row_kind;
  nted_pkg::out_item_t           row_typed;

  note_event_debouncer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  nted_pkg::out_item_t pending_notes[$];   // emitted notes and mutes still to arrive
  int        fail_cnt     = 0;
  int        n_events     = 0;
  int        n_results    = 0;
  int        n_settings   = 0;
  int        quiet_cycles = 0;
  bit        tx_steady    = 1'b0;  // sender offers back to back
  bit        rx_steady    = 1'b0;  // receiver never stalls
  bit        rx_hold_req  = 1'b0;  // ask the receiver for one long hold-off

  // ---------------------------------------------------------------------------
  // Debounce predictor: own copy of the machine and of the registers
  // ---------------------------------------------------------------------------
  nted_pkg::cfg_t      shadow_cfg;
  nted_pkg::mode_e     dbn_mode;
  logic [7:0]          run_cnt;
  logic [6:0]          peak_vel;
  logic [6:0]          peak_expr;
  nted_pkg::in_item_t  cand_evt;   // first event of the current candidate run
  nted_pkg::out_item_t held_evt;   // last emitted event

  function automatic void reset_model();
    shadow_cfg.hold_count             = nted_pkg::HOLD_COUNT_RST;
    shadow_cfg.large_jump_count       = nted_pkg::LARGE_JUMP_COUNT_RST;
    shadow_cfg.max_semitone_step      = nted_pkg::MAX_SEMITONE_STEP_RST;
    shadow_cfg.bend_change_step       = nted_pkg::BEND_CHANGE_STEP_RST;
    shadow_cfg.expression_change_step = nted_pkg::EXPR_CHANGE_STEP_RST;
    dbn_mode  = nted_pkg::MODE_CHANGING_NOTE;
    run_cnt   = 8'd1;
    peak_vel  = '0;
    peak_expr = '0;
    cand_evt  = '0;
    held_evt  = '0;
  endfunction

  function automatic int unsigned abs_delta(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void bump_run();
    if (run_cnt < nted_pkg::RUN_COUNT_MAX) run_cnt++;
  endfunction

  function automatic void open_candidate(nted_pkg::in_item_t ev);
    cand_evt  = ev;
    run_cnt   = 8'd1;
    peak_vel  = ev.velocity;
    peak_expr = ev.expression;
  endfunction

  function automatic void return_to_held();
    run_cnt   = 8'd1;
    dbn_mode  = nted_pkg::MODE_HOLD_NOTE;
    peak_vel  = '0;
    peak_expr = '0;
  endfunction

  // Advance the machine by one event; returns 1 when a note or mute is emitted.
  function automatic bit debounce_event(nted_pkg::in_item_t ev,
                                        output nted_pkg::out_item_t res);
    int unsigned jump;
    bit          is_small;
    bit          reached;
    res = '0;
    case (dbn_mode)
      nted_pkg::MODE_CHANGING_NOTE: begin
        if (ev.velocity == '0) begin
          dbn_mode = (held_evt.out_velocity == '0) ? nted_pkg::MODE_HOLD_MUTE
                                                   : nted_pkg::MODE_CHANGING_MUTE;
          run_cnt  = 8'd1;
          return 1'b0;
        end
        if (ev.note_number == cand_evt.note_number) begin
          bump_run();
          if (ev.velocity > peak_vel) begin
            peak_vel  = ev.velocity;
            peak_expr = ev.expression;
          end
        end else if (ev.note_number == held_evt.out_note) begin
          return_to_held();
          return 1'b0;
        end else begin
          open_candidate(ev);
        end
        jump     = abs_delta(held_evt.out_note, ev.note_number);
        is_small = (jump <= shadow_cfg.max_semitone_step);
        reached  = (run_cnt >= shadow_cfg.hold_count && (is_small || held_evt.out_note == '0))
                || (run_cnt >= shadow_cfg.large_jump_count && !is_small);
        if (!reached) return 1'b0;
        held_evt.out_note       = cand_evt.note_number;
        held_evt.out_bend       = cand_evt.pitch_bend;
        held_evt.out_velocity   = peak_vel;
        held_evt.out_expression = peak_expr;
        dbn_mode = nted_pkg::MODE_HOLD_NOTE;
        res = held_evt;
        return 1'b1;
      end
      nted_pkg::MODE_CHANGING_MUTE: begin
        if (ev.velocity == '0) begin
          bump_run();
        end else if (ev.note_number == held_evt.out_note) begin
          return_to_held();
          return 1'b0;
        end else begin
          open_candidate(ev);
          dbn_mode = nted_pkg::MODE_CHANGING_NOTE;
        end
        if (run_cnt < shadow_cfg.hold_count) return 1'b0;
        // The whole triggering event becomes the held event.
        held_evt.out_note       = ev.note_number;
        held_evt.out_velocity   = ev.velocity;
        held_evt.out_expression = ev.expression;
        held_evt.out_bend       = ev.pitch_bend;
        dbn_mode = nted_pkg::MODE_HOLD_MUTE;
        res = held_evt;
        return 1'b1;
      end
      nted_pkg::MODE_HOLD_NOTE: begin
        if (ev.note_number != held_evt.out_note) begin
          open_candidate(ev);
          dbn_mode = nted_pkg::MODE_CHANGING_NOTE;
          return 1'b0;
        end
        if (abs_delta(held_evt.out_bend, ev.pitch_bend) < shadow_cfg.bend_change_step &&
            abs_delta(held_evt.out_expression, ev.expression)
              < shadow_cfg.expression_change_step) return 1'b0;
        held_evt.out_bend       = ev.pitch_bend;
        held_evt.out_velocity   = ev.velocity;
        held_evt.out_expression = ev.expression;
        res = held_evt;
        return 1'b1;
      end
      default: begin
        // Hold mute: any sounding event opens a new candidate.
        if (ev.velocity != '0) begin
          open_candidate(ev);
          dbn_mode = nted_pkg::MODE_CHANGING_NOTE;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table, walked once right after reset under the reset settings.
  // Only the opening rows carry a typed result; the rest go to the predictor.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [24] = '{
    // first note from reset: held note is zero, so three repeats suffice
    '{ROW_QUIET,     {7'd60,  7'd100, 7'd64,  14'd8192},  '0},
    '{ROW_QUIET,     {7'd60,  7'd100, 7'd64,  14'd8192},  '0},
    '{ROW_EMITS,     {7'd60,  7'd100, 7'd64,  14'd8192},  {7'd60, 7'd100, 7'd64, 14'd8192}},
    // bend moves by exactly the step, then expression by exactly the step
    '{ROW_EMITS,     {7'd60,  7'd90,  7'd64,  14'd9792},  {7'd60, 7'd90, 7'd64, 14'd9792}},
    '{ROW_EMITS,     {7'd60,  7'd90,  7'd69,  14'd9792},  {7'd60, 7'd90, 7'd69, 14'd9792}},
    // expression one short of the step: stays quiet
    '{ROW_PREDICTED, {7'd60,  7'd90,  7'd73,  14'd9792},  '0},
    // semitone change with a rising peak velocity
    '{ROW_PREDICTED, {7'd61,  7'd120, 7'd10,  14'd100},   '0},
    '{ROW_PREDICTED, {7'd61,  7'd127, 7'd20,  14'd200},   '0},
    '{ROW_PREDICTED, {7'd61,  7'd110, 7'd30,  14'd300},   '0},
    // silence runs into a mute; the last event carries the maxima in every field but velocity
    '{ROW_PREDICTED, {7'd0,   7'd0,   7'd0,   14'd0},     '0},
    '{ROW_PREDICTED, {7'd0,   7'd0,   7'd0,   14'd0},     '0},
    '{ROW_PREDICTED, {7'd0,   7'd0,   7'd0,   14'd0},     '0},
    '{ROW_PREDICTED, {7'd127, 7'd0,   7'd127, 14'd16383}, '0},
    // leave hold mute with a note at every maximum
    '{ROW_PREDICTED, {7'd127, 7'd127, 7'd127, 14'd16383}, '0},
    '{ROW_PREDICTED, {7'd127, 7'd127, 7'd127, 14'd16383}, '0},
    '{ROW_PREDICTED, {7'd127, 7'd127, 7'd127, 14'd16383}, '0},
    // wander off, then come back to the held note
    '{ROW_PREDICTED, {7'd100, 7'd50,  7'd50,  14'd50},    '0},
    '{ROW_PREDICTED, {7'd127, 7'd50,  7'd50,  14'd50},    '0},
    // wide jump needs the longer count
    '{ROW_PREDICTED, {7'd20,  7'd64,  7'd0,   14'd0},     '0},
    '{ROW_PREDICTED, {7'd20,  7'd64,  7'd0,   14'd0},     '0},
    '{ROW_PREDICTED, {7'd20,  7'd64,  7'd0,   14'd0},     '0},
    '{ROW_PREDICTED, {7'd20,  7'd64,  7'd0,   14'd0},     '0},
    '{ROW_PREDICTED, {7'd20,  7'd64,  7'd0,   14'd0},     '0},
    '{ROW_PREDICTED, {7'd20,  7'd64,  7'd0,   14'd0},     '0}
  };

  // ---------------------------------------------------------------------------
  // Pacing helpers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, a few long ones.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // Scatter around a base so both sides of a change threshold get hit.
  function automatic int wobble(int base, int spread, int hi);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, hi);
    return clip(base + int'($urandom_range(0, 2 * spread)) - spread, hi);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall pattern, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : rx_pacing
    bit stall_val;
    int span;
    forever begin
      if (rx_hold_req) begin
        // Hold off long enough for the block to fill and stall its input.
        rx_hold_req = 1'b0;
        stall_val   = 1'b1;
        span        = HoldOffCycles;
      end else begin
        stall_val = !rx_steady && ($urandom_range(0, 2) == 0);
        span      = stall_val ? pick_gap(1'b0) + 1 : $urandom_range(1, 8);
      end
      out_stall <= stall_val;
      repeat (span) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Input monitor: run the predictor on every accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : in_monitor
    nted_pkg::out_item_t predicted;
    bit                  fired;
    if (rst_n && in_valid && !in_stall) begin
      n_events++;
      fired = debounce_event(in_item, predicted);
      case (row_kind)
        ROW_PREDICTED: if (fired) pending_notes.push_back(predicted);
        ROW_EMITS:     pending_notes.push_back(row_typed);
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : out_monitor
    nted_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_notes.size() == 0) begin
        $error("unexpected result: note %0d velocity %0d expression %0d bend %0d",
               out_item.out_note, out_item.out_velocity, out_item.out_expression,
               out_item.out_bend);
        fail_cnt++;
      end else begin
        want = pending_notes.pop_front();
        check_field("out_note",       want.out_note,       out_item.out_note);
        check_field("out_velocity",   want.out_velocity,   out_item.out_velocity);
        check_field("out_expression", want.out_expression, out_item.out_expression);
        check_field("out_bend",       want.out_bend,       out_item.out_bend);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no transaction of any kind moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one event and hold it until the transaction completes. Valid is
  // only dropped when a gap follows, never lowered and raised in one step.
  task automatic send_event(nted_pkg::in_item_t ev, row_kind_e kind,
                            nted_pkg::out_item_t typed);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item   <= ev;
    row_kind  <= kind;
    row_typed <= typed;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every expected result is in, then let the
  // pipeline run empty for events that emit nothing.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [nted_pkg::CfgIdxW-1:0] idx,
                           logic [nted_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      nted_pkg::CFG_HOLD_COUNT:        shadow_cfg.hold_count        = data[7:0];
      nted_pkg::CFG_LARGE_JUMP_COUNT:  shadow_cfg.large_jump_count  = data[7:0];
      nted_pkg::CFG_MAX_SEMITONE_STEP: shadow_cfg.max_semitone_step = data[6:0];
      nted_pkg::CFG_BEND_CHANGE_STEP:  shadow_cfg.bend_change_step  = data[13:0];
      nted_pkg::CFG_EXPR_CHANGE_STEP:  shadow_cfg.expression_change_step = data[6:0];
      default:                         ;
    endcase
  endtask

  // Load a full register setting; only done with the block idle.
  task automatic apply_setting(nted_pkg::cfg_t c);
    drain_results();
    write_reg(nted_pkg::CFG_HOLD_COUNT,        nted_pkg::CfgDataW'(c.hold_count));
    write_reg(nted_pkg::CFG_LARGE_JUMP_COUNT,  nted_pkg::CfgDataW'(c.large_jump_count));
    write_reg(nted_pkg::CFG_MAX_SEMITONE_STEP, nted_pkg::CfgDataW'(c.max_semitone_step));
    write_reg(nted_pkg::CFG_BEND_CHANGE_STEP,  c.bend_change_step);
    write_reg(nted_pkg::CFG_EXPR_CHANGE_STEP,
              nted_pkg::CfgDataW'(c.expression_change_step));
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // Random runs: mostly repeated notes or silences sized around the repeat
  // counts, with some raw noise. Runs aim near, far from, or at the held note.
  task automatic play_random(int budget, bit keep_steady);
    int                 sent;
    int                 len;
    int                 r;
    int                 k;
    int                 tgt;
    int                 step;
    int                 base_bend;
    int                 base_expr;
    bit                 mute_run;
    nted_pkg::in_item_t ev;
    sent = 0;
    while (sent < budget) begin
      if (!keep_steady) begin
        tx_steady = ($urandom_range(0, 9) == 0);
        rx_steady = tx_steady;
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        ev = '{7'($urandom), 7'($urandom), 7'($urandom), 14'($urandom)};
        send_event(ev, ROW_PREDICTED, '0);
        sent++;
        continue;
      end
      mute_run = (r < 27);
      len = (mute_run || $urandom_range(0, 1)) ? int'(shadow_cfg.hold_count)
                                               : int'(shadow_cfg.large_jump_count);
      len = len - 1 + int'($urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 4);
      if (len < 1) len = 1;
      // Sit on the note a bit longer so bend and expression re-emits happen.
      if (!mute_run) len += $urandom_range(0, 6);

      r = $urandom_range(0, 99);
      if (r < 30) begin
        step = $urandom_range(0, shadow_cfg.max_semitone_step + 1);
        if ($urandom_range(0, 1)) step = -step;
        tgt = clip(int'(held_evt.out_note) + step, 127);
      end else if (r < 40) begin
        tgt = held_evt.out_note;
      end else if (r < 50) begin
        tgt = $urandom_range(0, 1) ? 127 : 0;
      end else begin
        tgt = $urandom_range(0, 127);
      end
      base_bend = $urandom_range(0, 16383);
      base_expr = $urandom_range(0, 127);

      for (k = 0; k < len; k++) begin
        ev.note_number = mute_run ? 7'($urandom) : 7'(tgt);
        ev.velocity    = mute_run ? 7'd0 : 7'($urandom_range(1, 127));
        ev.expression  = 7'(wobble(base_expr, int'(shadow_cfg.expression_change_step) + 1, 127));
        ev.pitch_bend  = 14'(wobble(base_bend, int'(shadow_cfg.bend_change_step) + 1, 16383));
        // Break the odd run with a silence or a return to the held note.
        r = $urandom_range(0, 99);
        if (!mute_run && r < 3)      ev.velocity    = 7'd0;
        else if (!mute_run && r < 6) ev.note_number = held_evt.out_note;
        send_event(ev, ROW_PREDICTED, '0);
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    nted_pkg::cfg_t plan   [6];
    int             budget [6];
    int             i;

    in_valid  <= 1'b0;
    in_item   <= '0;
    row_kind  <= ROW_PREDICTED;
    row_typed <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    reset_model();

    // Settings: minima, maxima, two moderate random ones, a full random one,
    // and back to the reset values.
    plan[0] = '{8'd1, 8'd1, 7'd0, 14'd0, 7'd0};
    plan[1] = '{8'd255, 8'd255, 7'd127, 14'd16383, 7'd127};
    for (i = 2; i < 4; i++) begin
      plan[i].hold_count             = 8'($urandom_range(1, 12));
      plan[i].large_jump_count       = 8'($urandom_range(1, 20));
      plan[i].max_semitone_step      = 7'($urandom_range(0, 12));
      plan[i].bend_change_step       = 14'($urandom_range(0, 4000));
      plan[i].expression_change_step = 7'($urandom_range(0, 20));
    end
    plan[4].hold_count             = 8'($urandom_range(1, 40));
    plan[4].large_jump_count       = 8'($urandom_range(1, 40));
    plan[4].max_semitone_step      = 7'($urandom_range(0, 127));
    plan[4].bend_change_step       = 14'($urandom_range(0, 16383));
    plan[4].expression_change_step = 7'($urandom_range(0, 127));
    plan[5] = '{nted_pkg::HOLD_COUNT_RST, nted_pkg::LARGE_JUMP_COUNT_RST,
                nted_pkg::MAX_SEMITONE_STEP_RST, nted_pkg::BEND_CHANGE_STEP_RST,
                nted_pkg::EXPR_CHANGE_STEP_RST};
    budget = '{200, 500, 120, 120, 100, 60};

    // Hold reset, then release it on a clock edge.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset settings.
    foreach (directed_rows[i])
      send_event(directed_rows[i].ev, directed_rows[i].kind, directed_rows[i].typed);

    play_random(150, 1'b0);

    // Back-pressure: the receiver holds off while the sender keeps offering.
    tx_steady   = 1'b1;
    rx_steady   = 1'b0;
    rx_hold_req = 1'b1;
    play_random(50, 1'b1);
    tx_steady = 1'b0;

    // Pause the sender until every expected result is in, then resume.
    drain_results();
    play_random(50, 1'b0);

    for (i = 0; i < 6; i++) begin
      apply_setting(plan[i]);
      play_random(budget[i], 1'b0);
    end

    drain_results();
    $display("Summary: %0d events under %0d register settings, %0d results checked",
             n_events, n_settings + 1, n_results);
    if (fail_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/nted_pkg.sv
src/nted_cfg.sv
src/nted_core.sv
src/note_event_debouncer.sv
src/nted_checker.sv
bench/tb_note_event_debouncer.sv
